FILE: rtl/fct_pkg.sv
// Shared types and constants for the frustum cull test block.
package fct_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_REGS   = 8;
  localparam int NRM_BITS   = 30;
  localparam int COEF_W     = 33;
  localparam int SQ_W       = 68;
  localparam int ROOT_W     = 34;
  localparam int NUM_W      = 63;
  localparam int IDX_W      = 4;

  localparam logic [1:0] CMD_POINT  = 2'd0;
  localparam logic [1:0] CMD_SPHERE = 2'd1;
  localparam logic [1:0] CMD_BOX    = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] bz;
    logic [30:0] rad;
    logic        vis;
  } item_t;

  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [31:0] d;
  } plane_t;

  typedef struct packed {
    logic       we;
    logic [2:0] idx;
    plane_t     plane;
  } plane_wr_t;

  typedef struct packed {
    logic                  busy;
    logic                  ready;
    logic [NUM_PLANES-1:0] mask;
  } status_t;

endpackage

FILE: rtl/fct_deriver.sv
// Plane derivation sequencer: holds the matrix, squares, roots and divides per plane.
module fct_deriver #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fct_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]               cfg_data_i,
  output fct_pkg::plane_wr_t        wr_o,
  output fct_pkg::status_t          status_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_COEF, ST_SQ, ST_ROOT, ST_DIV, ST_STORE
  } state_e;

  state_e                          state_q;
  logic [63:0]                     cfg_q [fct_pkg::NUM_REGS];
  logic [2:0]                      plane_q;
  logic [5:0]                      cnt_q;
  logic [1:0]                      comp_q;
  logic [fct_pkg::COEF_W-1:0]      coef_q [4];
  logic [fct_pkg::COEF_W-1:0]      coef_d [4];
  logic [fct_pkg::SQ_W-1:0]        acc_q;
  logic [36:0]                     rem_q;
  logic [fct_pkg::ROOT_W-1:0]      root_q;
  logic [34:0]                     drem_q;
  logic [fct_pkg::NUM_W-1:0]       num_q;
  logic [31:0]                     res_q [4];
  logic                            ready_q;
  logic [fct_pkg::NUM_PLANES-1:0]  mask_q;

  logic                            cfg_hit;
  logic [fct_pkg::COEF_W-1:0]      cur_mag;
  logic [65:0]                     sq_prod;
  logic [36:0]                     rem_t;
  logic [36:0]                     trial;
  logic [34:0]                     drem_t;
  logic                            dbit;
  logic [fct_pkg::NUM_W-1:0]       qfin;
  logic [31:0]                     res_val;
  logic [fct_pkg::NUM_W-1:0]       num_start;

  function automatic logic [fct_pkg::COEF_W-1:0] mag(input logic [fct_pkg::COEF_W-1:0] v);
    mag = v[fct_pkg::COEF_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [fct_pkg::COEF_W-1:0] entry(input logic [63:0] reg_v,
                                                        input logic hi);
    entry = hi ? {reg_v[63], reg_v[63:32]} : {reg_v[31], reg_v[31:0]};
  endfunction

  assign cfg_hit = cfg_we_i && (cfg_idx_i < fct_pkg::IDX_W'(fct_pkg::NUM_REGS));

  always_comb begin
    logic [2:0] k;
    k = {1'b0, plane_q[2:1]};
    for (int c = 0; c < 4; c++) begin
      logic [fct_pkg::COEF_W-1:0] a;
      logic [fct_pkg::COEF_W-1:0] b;
      a = entry(cfg_q[6 + c / 2], c[0]);
      b = entry(cfg_q[3'(k * 2) + 3'(c / 2)], c[0]);
      coef_d[c] = plane_q[0] ? (a - b) : (a + b);
    end
  end

  assign cur_mag   = mag(coef_q[comp_q]);
  assign sq_prod   = cur_mag * cur_mag;
  assign rem_t     = {rem_q[34:0], acc_q[fct_pkg::SQ_W-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign drem_t    = {drem_q[33:0], num_q[fct_pkg::NUM_W-1]};
  assign dbit      = drem_t >= {1'b0, root_q};
  assign qfin      = {num_q[fct_pkg::NUM_W-2:0], dbit};
  assign num_start = (fct_pkg::NUM_W'(cur_mag)) << ((comp_q == 2'd3) ? FRAC_BITS
                                                                    : fct_pkg::NRM_BITS);

  // Sign and, for the offset term, saturate the finished quotient.
  always_comb begin
    logic neg;
    neg = coef_q[comp_q][fct_pkg::COEF_W-1];
    if (comp_q != 2'd3) begin
      res_val = neg ? (~qfin[31:0] + 1'b1) : qfin[31:0];
    end else if (neg) begin
      res_val = (qfin >= fct_pkg::NUM_W'(64'h8000_0000)) ? 32'h8000_0000
                                                         : (~qfin[31:0] + 1'b1);
    end else begin
      res_val = (qfin > fct_pkg::NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qfin[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
      mask_q  <= '0;
      plane_q <= '0;
      cnt_q   <= '0;
      comp_q  <= '0;
      for (int i = 0; i < fct_pkg::NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_hit) begin
      cfg_q[cfg_idx_i[2:0]] <= cfg_data_i;
      state_q <= ST_COEF;
      plane_q <= '0;
      mask_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
        end
        ST_COEF: begin
          for (int c = 0; c < 4; c++) coef_q[c] <= coef_d[c];
          acc_q   <= '0;
          comp_q  <= '0;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          if (comp_q == 2'd2) begin
            if ((acc_q + fct_pkg::SQ_W'(sq_prod)) == '0) begin
              mask_q[plane_q] <= 1'b1;
              for (int c = 0; c < 4; c++) res_q[c] <= '0;
              state_q <= ST_STORE;
            end else begin
              state_q <= ST_ROOT;
            end
            acc_q  <= acc_q + fct_pkg::SQ_W'(sq_prod);
            rem_q  <= '0;
            root_q <= '0;
            cnt_q  <= 6'(fct_pkg::ROOT_W - 1);
          end else begin
            acc_q  <= acc_q + fct_pkg::SQ_W'(sq_prod);
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_ROOT: begin
          // One result bit per cycle, two radicand bits shifted in.
          acc_q <= {acc_q[fct_pkg::SQ_W-3:0], 2'b00};
          if (rem_t >= trial) begin
            rem_q  <= rem_t - trial;
            root_q <= {root_q[fct_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= rem_t;
            root_q <= {root_q[fct_pkg::ROOT_W-2:0], 1'b0};
          end
          if (cnt_q == '0) begin
            state_q <= ST_DIV;
            comp_q  <= '0;
            cnt_q   <= 6'(fct_pkg::NUM_W);
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'(fct_pkg::NUM_W)) begin
            num_q  <= num_start;
            drem_q <= '0;
            cnt_q  <= cnt_q - 6'd1;
          end else begin
            drem_q <= dbit ? (drem_t - {1'b0, root_q}) : drem_t;
            num_q  <= qfin;
            if (cnt_q == '0) begin
              res_q[comp_q] <= res_val;
              cnt_q <= 6'(fct_pkg::NUM_W);
              if (comp_q == 2'd3) state_q <= ST_STORE;
              else comp_q <= comp_q + 2'd1;
            end else begin
              cnt_q <= cnt_q - 6'd1;
            end
          end
        end
        ST_STORE: begin
          if (plane_q == 3'(fct_pkg::NUM_PLANES - 1)) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end else begin
            plane_q <= plane_q + 3'd1;
            state_q <= ST_COEF;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign wr_o.we       = (state_q == ST_STORE) && !cfg_hit;
  assign wr_o.idx      = plane_q;
  assign wr_o.plane    = {res_q[0], res_q[1], res_q[2], res_q[3]};
  assign status_o.busy  = (state_q != ST_IDLE);
  assign status_o.ready = ready_q;
  assign status_o.mask  = mask_q;

endmodule

FILE: rtl/fct_cell.sv
// One plane cell: holds a plane and tests each passing word against it in two stages.
module fct_cell #(
  parameter logic [2:0] PLANE_IDX = 3'd0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  fct_pkg::plane_wr_t wr_i,
  input  logic               valid_i,
  input  fct_pkg::item_t     item_i,
  output logic               valid_o,
  output fct_pkg::item_t     item_o
);

  fct_pkg::plane_t    pl_q;
  logic               va_q, vb_q;
  fct_pkg::item_t     ia_q, ib_q;
  fct_pkg::item_t     ib_d;
  logic signed [63:0] p0_q, p1_q, p2_q;
  logic [31:0]        da_q;
  logic signed [31:0] sx, sy, sz;
  logic signed [65:0] dist_sum, thr;
  logic               fail;

  always_comb begin
    logic box;
    box = item_i.cmd[1];
    sx = $signed((box && !pl_q.nx[31]) ? item_i.bx : item_i.ax);
    sy = $signed((box && !pl_q.ny[31]) ? item_i.by : item_i.ay);
    sz = $signed((box && !pl_q.nz[31]) ? item_i.bz : item_i.az);
  end

  assign dist_sum = 66'(p0_q) + 66'(p1_q) + 66'(p2_q)
                  + (66'($signed(da_q)) <<< fct_pkg::NRM_BITS);
  assign thr  = (ia_q.cmd == fct_pkg::CMD_SPHERE)
              ? -($signed({35'b0, ia_q.rad}) <<< fct_pkg::NRM_BITS) : 66'sd0;
  assign fail = dist_sum < thr;

  always_comb begin
    ib_d     = ia_q;
    ib_d.vis = ia_q.vis & ~fail;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_i.idx == PLANE_IDX) pl_q <= wr_i.plane;
    if (en_i) begin
      p0_q <= $signed(pl_q.nx) * sx;
      p1_q <= $signed(pl_q.ny) * sy;
      p2_q <= $signed(pl_q.nz) * sz;
      da_q <= pl_q.d;
      ia_q <= item_i;
      ib_q <= ib_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  assign valid_o = vb_q;
  assign item_o  = ib_q;

endmodule

FILE: rtl/frustum_cull_test_top.sv
// Top level of the frustum cull test: plane derivation and a chain of six plane cells.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid_i/in_ready_o | cmd_i ax_i ay_i az_i bx_i by_i bz_i
//           |                       | sphere_radius_i
//  output   | out_valid_o/out_ready_i | visible_o degenerate_o
//  config   | cfg_we_i              | cfg_idx_i cfg_data_i
//
// One word is accepted per cycle while the chain advances and no derivation runs; each word
// passes through six cells of two stages each and then one output register.
// A configuration write starts a plane derivation (per plane: coefficients, three squares,
// a 34-step square root and four 63-step divisions; a plane with a zero normal skips the
// root and the divisions); in_ready_o is low throughout.
// Reset clears the matrix, the ready flag and the mask.
// A stalled output freezes the whole chain; in_ready_o then drops in the same cycle.
module frustum_cull_test_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fct_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic signed [31:0]        ax_i,
  input  logic signed [31:0]        ay_i,
  input  logic signed [31:0]        az_i,
  input  logic signed [31:0]        bx_i,
  input  logic signed [31:0]        by_i,
  input  logic signed [31:0]        bz_i,
  input  logic [30:0]               sphere_radius_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      visible_o,
  output logic                      degenerate_o
);

  fct_pkg::plane_wr_t wr;
  fct_pkg::status_t   status;
  logic               en;
  logic               valid_c [fct_pkg::NUM_PLANES+1];
  fct_pkg::item_t     item_c  [fct_pkg::NUM_PLANES+1];
  logic               out_valid_q;
  logic               visible_q, degenerate_q;

  fct_deriver #(.FRAC_BITS(FRAC_BITS)) u_deriver (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .wr_o(wr), .status_o(status)
  );

  // The whole chain advances whenever the output register is free or being emptied.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en && !status.busy;

  assign valid_c[0] = in_valid_i && in_ready_o;
  assign item_c[0]  = '{cmd: cmd_i, ax: ax_i, ay: ay_i, az: az_i, bx: bx_i, by: by_i,
                        bz: bz_i, rad: sphere_radius_i, vis: 1'b1};

  for (genvar g = 0; g < fct_pkg::NUM_PLANES; g++) begin : g_cell
    fct_cell #(.PLANE_IDX(3'(g))) u_cell (
      .clk_i, .rst_ni, .en_i(en), .wr_i(wr),
      .valid_i(valid_c[g]), .item_i(item_c[g]),
      .valid_o(valid_c[g+1]), .item_o(item_c[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c[fct_pkg::NUM_PLANES];
    end
  end

  // Before any plane exists every object is visible and nothing is degenerate.
  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_q    <= !status.ready || item_c[fct_pkg::NUM_PLANES].vis;
      degenerate_q <= status.ready && (status.mask != '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign visible_o    = visible_q;
  assign degenerate_o = degenerate_q;

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !in_ready_o) else $error("word accepted during plane derivation");

  a_cfg_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i < fct_pkg::IDX_W'(fct_pkg::NUM_REGS)) |=> status.busy)
    else $error("configuration write did not start derivation");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the frustum cull test block.
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int NUM_PHASES = 6;

  // The fourth code: bit 1 selects the box test, so it behaves as one.
  localparam logic [1:0] CMD_BOX_ALIAS = 2'd3;
  // Register indexes beyond the matrix are ignored by the block.
  localparam logic [3:0] REG_ROW0_01 = 4'd0;
  localparam logic [3:0] REG_ROW1_01 = 4'd2;
  localparam logic [3:0] REG_ROW2_23 = 4'd5;
  localparam logic [3:0] REG_ROW3_23 = 4'd7;
  localparam logic [3:0] REG_OUT_OF_RANGE = 4'd9;

  // Idle patterns for the two sides of the block.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH = 3;

  // Matrix styles for the random phases.
  localparam int MAT_SMALL = 0;
  localparam int MAT_EXTREME = 1;
  localparam int MAT_FULL = 2;
  localparam int MAT_FLAT = 3;

  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] bx, by, bz;
    logic [30:0]        rad;
  } cull_word_t;

  typedef struct {
    logic vis;
    logic deg;
  } verdict_t;

  // One row of the directed table: either a register write or a word.
  // Typed rows carry their expected verdict; the rest use the predictor.
  typedef struct {
    logic       is_cfg;
    logic [3:0] idx;
    logic [63:0] data;
    cull_word_t w;
    logic       typed;
    verdict_t   verdict;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fct_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  logic signed [31:0] ax_i = '0, ay_i = '0, az_i = '0;
  logic signed [31:0] bx_i = '0, by_i = '0, bz_i = '0;
  logic [30:0] sphere_radius_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b1;
  logic visible_o;
  logic degenerate_o;

  frustum_cull_test_top #(.FRAC_BITS(FRAC)) dut (.*);

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the block's matrix and derived planes.
  logic [63:0] matrix_reg [fct_pkg::NUM_REGS];
  int          plane_coef [fct_pkg::NUM_PLANES*4];
  bit          planes_valid;
  bit [fct_pkg::NUM_PLANES-1:0] flat_mask;

  verdict_t verdicts_due [$];
  dir_row_t dir_rows [$];
  int  idle_mode = IDLE_NONE;
  int  fail_count = 0;
  int  quiet_cycles = 0;

  function automatic logic signed [33:0] mat_entry(int r, int c);
    logic [63:0] rv;
    logic signed [31:0] h;
    rv = matrix_reg[r*2 + c/2];
    h = (c % 2) ? rv[63:32] : rv[31:0];
    return h;
  endfunction

  // Rebuild the six planes from the matrix: row 3 plus and minus rows 0..2,
  // each divided by the floored length of its normal.
  function automatic void derive_planes();
    logic signed [33:0] co [4];
    logic [33:0]  mag [4];
    logic [127:0] sq, root, cand, quo;
    int k;
    flat_mask = '0;
    for (int p = 0; p < fct_pkg::NUM_PLANES; p++) begin
      k = p / 2;
      sq = '0;
      for (int c = 0; c < 4; c++) begin
        co[c] = (p % 2) ? mat_entry(3, c) - mat_entry(k, c) : mat_entry(3, c) + mat_entry(k, c);
        mag[c] = co[c] < 0 ? -co[c] : co[c];
      end
      for (int c = 0; c < 3; c++) sq += 128'(mag[c]) * 128'(mag[c]);
      if (sq == 0) begin
        // A zero-length normal passes every test and raises its mask bit.
        flat_mask[p] = 1'b1;
        for (int c = 0; c < 4; c++) plane_coef[p*4+c] = 0;
        continue;
      end
      root = '0;
      for (int b = fct_pkg::ROOT_W; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= sq) root = cand;
      end
      for (int c = 0; c < 3; c++) begin
        quo = (128'(mag[c]) << fct_pkg::NRM_BITS) / root;
        plane_coef[p*4+c] = co[c] < 0 ? -int'(quo[31:0]) : int'(quo[31:0]);
      end
      quo = (128'(mag[3]) << FRAC) / root;
      if (co[3] < 0)
        plane_coef[p*4+3] = quo >= 128'h8000_0000 ? 32'h8000_0000 : -int'(quo[31:0]);
      else
        plane_coef[p*4+3] = quo > 128'h7fff_ffff ? 32'h7fff_ffff : int'(quo[31:0]);
    end
  endfunction

  function automatic longint plane_distance(int p, logic signed [31:0] x,
                                            logic signed [31:0] y, logic signed [31:0] z);
    return longint'(plane_coef[p*4]) * longint'(x) + longint'(plane_coef[p*4+1]) * longint'(y)
         + longint'(plane_coef[p*4+2]) * longint'(z)
         + longint'(plane_coef[p*4+3]) * (64'sd1 <<< fct_pkg::NRM_BITS);
  endfunction

  function automatic verdict_t cull_verdict(cull_word_t w);
    verdict_t v;
    longint pdist;
    v.vis = 1'b1;
    v.deg = planes_valid && (flat_mask != 0);
    if (planes_valid) begin
      for (int p = 0; p < fct_pkg::NUM_PLANES; p++) begin
        if (flat_mask[p]) continue;
        if (w.cmd[1]) begin
          // Positive vertex: the max corner along each non-negative normal axis.
          pdist = plane_distance(p, plane_coef[p*4] >= 0 ? w.bx : w.ax,
                                 plane_coef[p*4+1] >= 0 ? w.by : w.ay,
                                 plane_coef[p*4+2] >= 0 ? w.bz : w.az);
          if (pdist < 0) v.vis = 1'b0;
        end else if (w.cmd == fct_pkg::CMD_SPHERE) begin
          pdist = plane_distance(p, w.ax, w.ay, w.az);
          if (pdist < -(longint'(w.rad) <<< fct_pkg::NRM_BITS)) v.vis = 1'b0;
        end else begin
          pdist = plane_distance(p, w.ax, w.ay, w.az);
          if (pdist < 0) v.vis = 1'b0;
        end
      end
    end
    return v;
  endfunction

  function automatic bit roll_idle(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // The receiver stalls at random according to the current idle mode.
  always @(negedge clk_i) begin
    out_ready_i <= !roll_idle(idle_mode == IDLE_RECEIVER ? 74 : idle_mode == IDLE_BOTH ? 20 : 0);
  end

  // Compare each result word with the oldest verdict still due.
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_due.size() == 0) begin
        $error("result word with no verdict due: visible %0d degenerate %0d",
               visible_o, degenerate_o);
        fail_count++;
      end else begin
        v = verdicts_due.pop_front();
        if (visible_o !== v.vis) begin
          $error("visible: expected %0d, got %0d", v.vis, visible_o);
          fail_count++;
        end
        if (degenerate_o !== v.deg) begin
          $error("degenerate: expected %0d, got %0d", v.deg, degenerate_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving in either direction. The limit covers
  // a full plane derivation after a register write plus a long receiver stall.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Send one word, holding it until accepted. Returns just after the accepting edge.
  // The verdict is queued at acceptance; typed rows supply their own.
  task automatic send_word(cull_word_t w, logic typed, verdict_t typed_v);
    @(negedge clk_i);
    while (roll_idle(idle_mode == IDLE_SENDER ? 74 : idle_mode == IDLE_BOTH ? 20 : 0)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= w.cmd;
    ax_i <= w.ax;
    ay_i <= w.ay;
    az_i <= w.az;
    bx_i <= w.bx;
    by_i <= w.by;
    bz_i <= w.bz;
    sphere_radius_i <= w.rad;
    do @(posedge clk_i); while (!in_ready_o);
    verdicts_due.push_back(typed ? typed_v : cull_verdict(w));
  endtask

  // Register writes happen only with the block idle, then wait out the derivation.
  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < fct_pkg::NUM_REGS) begin
      matrix_reg[idx] = data;
      derive_planes();
      planes_valid = 1'b1;
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic void add_cfg(logic [3:0] idx, logic [63:0] data);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    r.typed = 1'b0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_word(logic [1:0] cmd, logic [31:0] ax, logic [31:0] ay,
                                   logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                   logic [31:0] bz, logic [30:0] rad,
                                   logic typed = 1'b0, logic vis = 1'b0, logic deg = 1'b0);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.w = '{cmd, ax, ay, az, bx, by, bz, rad};
    r.typed = typed;
    r.verdict = '{vis, deg};
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  function automatic cull_word_t rand_word();
    cull_word_t w;
    w.cmd = $urandom_range(0, 9) == 0 ? CMD_BOX_ALIAS : 2'($urandom_range(0, 2));
    w.ax = rand_coord();
    w.ay = rand_coord();
    w.az = rand_coord();
    if ($urandom_range(0, 4) != 0) begin
      // Mostly well-formed boxes: max sits at or above min on every axis.
      w.bx = w.ax + $urandom_range(0, 1 << 18);
      w.by = w.ay + $urandom_range(0, 1 << 18);
      w.bz = w.az + $urandom_range(0, 1 << 18);
    end else begin
      w.bx = rand_coord();
      w.by = rand_coord();
      w.bz = rand_coord();
    end
    w.rad = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
    return w;
  endfunction

  function automatic logic [31:0] rand_entry(int style);
    case (style)
      MAT_EXTREME: begin
        case ($urandom_range(0, 2))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          default: return 32'h0;
        endcase
      end
      MAT_FULL: return $urandom;
      default: return $urandom_range(0, 1 << 18) - (1 << 17);
    endcase
  endfunction

  // Build a fresh matrix of the given style and write all eight registers.
  task automatic load_matrix(int style);
    logic [31:0] m [4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = rand_entry(style);
    if (style == MAT_FLAT) begin
      // Row 0 normal equal to row 3 gives a zero normal on the minus plane.
      for (int c = 0; c < 3; c++) m[0][c] = m[3][c];
    end
    for (int r = 0; r < 4; r++) begin
      write_reg(4'(r*2), {m[r][1], m[r][0]});
      write_reg(4'(r*2+1), {m[r][3], m[r][2]});
    end
  endtask

  initial begin
    dir_row_t row;
    for (int i = 0; i < fct_pkg::NUM_REGS; i++) matrix_reg[i] = '0;
    for (int i = 0; i < fct_pkg::NUM_PLANES*4; i++) plane_coef[i] = 0;
    planes_valid = 1'b0;
    flat_mask = '0;

    // Before any write no planes exist, so every word is visible.
    add_word(fct_pkg::CMD_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0,
             31'h0, 1'b1, 1'b1, 1'b0);
    add_word(fct_pkg::CMD_SPHERE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h0,
             32'h0, 31'h7fff_ffff, 1'b1, 1'b1, 1'b0);
    add_word(fct_pkg::CMD_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 31'h0, 1'b1, 1'b1, 1'b0);
    // An all-zero matrix leaves every normal flat: visible, flagged degenerate.
    add_cfg(REG_ROW0_01, 64'h0);
    add_word(fct_pkg::CMD_POINT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0,
             1'b1, 1'b1, 1'b1);
    add_word(fct_pkg::CMD_BOX, 32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0,
             31'h0, 1'b1, 1'b1, 1'b1);
    // Identity matrix: the unit cube from -1 to +1 on each axis.
    add_cfg(REG_ROW0_01, {32'h0, ONE});
    add_cfg(REG_ROW1_01, {ONE, 32'h0});
    add_cfg(REG_ROW2_23, {32'h0, ONE});
    add_cfg(REG_ROW3_23, {ONE, 32'h0});
    add_word(fct_pkg::CMD_POINT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0);
    add_word(fct_pkg::CMD_POINT, ONE, -ONE, ONE, 32'h0, 32'h0, 32'h0, 31'h0);
    add_word(fct_pkg::CMD_POINT, ONE + 1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0);
    add_word(fct_pkg::CMD_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0,
             32'h0, 31'h0);
    add_word(fct_pkg::CMD_SPHERE, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
             31'h0001_0000);
    add_word(fct_pkg::CMD_SPHERE, 32'h0002_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
             31'h0001_0000);
    add_word(fct_pkg::CMD_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
             32'h0, 31'h7fff_ffff);
    add_word(fct_pkg::CMD_BOX, 32'h0001_8000, 32'h0, 32'h0, 32'h0003_0000, ONE, ONE, 31'h0);
    add_word(fct_pkg::CMD_BOX, 32'h0002_0000, 32'h0, 32'h0, 32'h0003_0000, ONE, ONE, 31'h0);
    // Code 3 runs as a box test.
    add_word(CMD_BOX_ALIAS, -ONE, -ONE, -ONE, ONE, ONE, ONE, 31'h0);
    // Box with min above max is taken as given.
    add_word(fct_pkg::CMD_BOX, ONE, ONE, ONE, -ONE, -ONE, -ONE, 31'h0);
    add_word(fct_pkg::CMD_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 31'h0);
    // A write beyond the matrix changes nothing.
    add_cfg(REG_OUT_OF_RANGE, 64'hffff_ffff_ffff_ffff);
    add_word(fct_pkg::CMD_POINT, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0, 32'h0,
             32'h0, 31'h0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, with no idling.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) write_reg(row.idx, row.data);
      else send_word(row.w, row.typed, row.verdict);
    end

    // Random phases: each loads a new matrix, and the idle pattern cycles through the four modes by phase.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_mode = IDLE_NONE;
      load_matrix(ph % 4);
      idle_mode = ph % 4;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_word(rand_word(), 1'b0, '{1'b0, 1'b0});
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fct_pkg.sv
rtl/fct_deriver.sv
rtl/fct_cell.sv
rtl/frustum_cull_test_top.sv
dv/testbench.sv
